[rtl/chps_pkg.sv]
// Shared constants and types for the cell handoff policy select unit.
package chps_pkg;

    localparam int IN_W       = 24;
    localparam int OUT_W      = 40;
    localparam int FRAC_BITS  = 24;
    localparam int MANT_BITS  = 31;
    localparam int LANE_LAT   = 3 + FRAC_BITS + 2;
    localparam int CFG_ADDR_W = 3;

    localparam logic [29:0] TEN_LOG10_2_Q28 = 30'd808071242;
    localparam logic signed [15:0] PWR_MAX = 16'sh7FFF;
    localparam logic signed [15:0] PWR_MIN = 16'sh8000;

    localparam logic [CFG_ADDR_W-1:0] REG_POLICY_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HYSTERESIS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_LEVEL   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TX_POWER    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_STATION_X   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_STATION_Y   = 3'd6;

    typedef enum logic [1:0] {
        MODE_BEST   = 2'd0,
        MODE_THRESH = 2'd1,
        MODE_HYST   = 2'd2,
        MODE_BOTH   = 2'd3
    } policy_mode_t;

    typedef struct packed {
        logic [1:0] srv;
        logic [1:0] alt;
    } item_t;

endpackage

[rtl/cell_handoff_policy_select_unit.sv]
// Top level: station power lanes, a station scan pipeline and the configuration registers.
// Requests pass the station lanes, then sc_reg[0] and the station scan stages to the result.
// Throughput: one request per cycle; each station lane runs 24 registered squaring steps.
// A stalled result freezes the whole pipeline, so s_tready follows m_tready while a result waits.
// Reset (aresetn low, synchronous) clears all valid bits and loads the register defaults.
module cell_handoff_policy_select_unit #(
    parameter int NUM_STATIONS = 4,
    parameter int COORD_BITS   = 11
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // pos_x, pos_y, serving_station, alt_station
    input  logic [chps_pkg::IN_W-1:0]               s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // new_serving_station, serving_power, new_alt_station, alt_power,
    // serving_handoff, alt_handoff, zero padding
    output logic [chps_pkg::OUT_W-1:0]              m_tdata,
    input  logic                                    cfg_we,
    input  logic [chps_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [((NUM_STATIONS*COORD_BITS > 64) ? 64
                   : NUM_STATIONS*COORD_BITS)-1:0]  cfg_wdata
);
    import chps_pkg::*;

    localparam int PW  = NUM_STATIONS * COORD_BITS;
    localparam int SPW = (PW > 64) ? 64 : PW;
    localparam int IW  = ($clog2(NUM_STATIONS) > 2) ? $clog2(NUM_STATIONS) : 2;

    typedef struct packed {
        logic [IW-1:0]                   srv;
        logic [IW-1:0]                   alt;
        logic [1:0]                      srv0;
        logic [1:0]                      alt0;
        logic signed [15:0]              psrv;
        logic signed [15:0]              palt;
        logic [NUM_STATIONS-1:0][15:0]   pw;
    } scan_t;

    logic               en;
    policy_mode_t       mode_reg;
    logic signed [7:0]  thr_reg;
    logic [6:0]         hys_reg;
    logic signed [7:0]  minlvl_reg;
    logic [6:0]         tx_reg;
    logic [SPW-1:0]     stx_reg, sty_reg;
    logic [PW-1:0]      stx_full, sty_full;

    logic               dl_valid_reg [0:LANE_LAT-1];
    item_t              dl_item_reg  [0:LANE_LAT-1];
    logic [NUM_STATIONS-1:0][15:0] lane_pw;

    logic               sc_valid_reg [0:NUM_STATIONS];
    scan_t              sc_reg       [0:NUM_STATIONS];
    scan_t              init_next;

    function automatic logic wins(input logic signed [15:0] pnew,
                                  input logic signed [15:0] pcur,
                                  input policy_mode_t       mode,
                                  input logic signed [7:0]  thr,
                                  input logic [6:0]         hys);
        logic signed [17:0] pn, pc, th, hy;
        logic               gt_plain, gt_hys, below;
        pn = 18'(pnew);
        pc = 18'(pcur);
        th = $signed({{2{thr[7]}}, thr, 8'b0});
        hy = $signed({3'b0, hys, 8'b0});
        gt_plain = pn > pc;
        gt_hys   = pn > (pc + hy);
        below    = pc < th;
        case (mode)
            MODE_BEST:   wins = gt_plain;
            MODE_THRESH: wins = gt_plain && below;
            MODE_HYST:   wins = gt_hys;
            MODE_BOTH:   wins = below && gt_hys;
            default:     wins = gt_plain;
        endcase
    endfunction

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign stx_full = PW'(stx_reg);
    assign sty_full = PW'(sty_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_BEST;
            thr_reg    <= 8'sd15;
            hys_reg    <= 7'd13;
            minlvl_reg <= 8'sd10;
            tx_reg     <= 7'd100;
            stx_reg    <= SPW'(64'd5498943611240);
            sty_reg    <= SPW'(64'd2664349078184);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_POLICY_MODE: mode_reg   <= policy_mode_t'(cfg_wdata[1:0]);
                REG_THRESHOLD:   thr_reg    <= cfg_wdata[7:0];
                REG_HYSTERESIS:  hys_reg    <= cfg_wdata[6:0];
                REG_MIN_LEVEL:   minlvl_reg <= cfg_wdata[7:0];
                REG_TX_POWER:    tx_reg     <= cfg_wdata[6:0];
                REG_STATION_X:   stx_reg    <= cfg_wdata;
                REG_STATION_Y:   sty_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_STATIONS; i++) begin : g_lane
        chps_power #(.COORD_BITS(COORD_BITS)) u_power (
            .aclk        (aclk),
            .en          (en),
            .pos_x       (s_tdata[9:0]),
            .pos_y       (s_tdata[19:10]),
            .stn_x       (stx_full[i*COORD_BITS +: COORD_BITS]),
            .stn_y       (sty_full[i*COORD_BITS +: COORD_BITS]),
            .tx_power_db (tx_reg),
            .power       (lane_pw[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                dl_valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dl_valid_reg[0] <= s_tvalid;
            for (int k = 1; k < LANE_LAT; k++) begin
                dl_valid_reg[k] <= dl_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_item_reg[0] <= '{srv: s_tdata[21:20], alt: s_tdata[23:22]};
            for (int k = 1; k < LANE_LAT; k++) begin
                dl_item_reg[k] <= dl_item_reg[k-1];
            end
        end
    end

    always_comb begin
        init_next      = '0;
        init_next.srv0 = dl_item_reg[LANE_LAT-1].srv;
        init_next.alt0 = dl_item_reg[LANE_LAT-1].alt;
        init_next.srv  = IW'(dl_item_reg[LANE_LAT-1].srv);
        init_next.alt  = IW'(dl_item_reg[LANE_LAT-1].alt);
        init_next.pw   = lane_pw;
        init_next.psrv = PWR_MIN;
        init_next.palt = PWR_MIN;
        for (int j = 0; j < NUM_STATIONS; j++) begin
            if (init_next.srv == IW'(j)) begin
                init_next.psrv = $signed(lane_pw[j]);
            end
            if (init_next.alt == IW'(j)) begin
                init_next.palt = $signed(lane_pw[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NUM_STATIONS; k++) begin
                sc_valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            sc_valid_reg[0] <= dl_valid_reg[LANE_LAT-1];
            for (int k = 1; k <= NUM_STATIONS; k++) begin
                sc_valid_reg[k] <= sc_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg[0] <= init_next;
        end
    end

    for (genvar i = 0; i < NUM_STATIONS; i++) begin : g_scan
        scan_t              cur, nxt;
        logic signed [15:0] p;
        logic signed [17:0] minlvl;
        always_comb begin
            cur    = sc_reg[i];
            nxt    = cur;
            p      = $signed(cur.pw[i]);
            minlvl = $signed({{2{minlvl_reg[7]}}, minlvl_reg, 8'b0});
            if (wins(p, cur.psrv, mode_reg, thr_reg, hys_reg)) begin
                nxt.psrv = p;
                nxt.srv  = IW'(i);
            end
            if (wins(p, cur.palt, mode_reg, thr_reg, hys_reg) && (18'(cur.palt) < minlvl)) begin
                nxt.palt = p;
                nxt.alt  = IW'(i);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sc_reg[i+1] <= nxt;
            end
        end
    end

    assign m_tvalid = sc_valid_reg[NUM_STATIONS];
    assign m_tdata  = {2'b0,
                       sc_reg[NUM_STATIONS].alt != IW'(sc_reg[NUM_STATIONS].alt0),
                       sc_reg[NUM_STATIONS].srv != IW'(sc_reg[NUM_STATIONS].srv0),
                       sc_reg[NUM_STATIONS].palt,
                       sc_reg[NUM_STATIONS].alt[1:0],
                       sc_reg[NUM_STATIONS].psrv,
                       sc_reg[NUM_STATIONS].srv[1:0]};

endmodule

[rtl/chps_power.sv]
// Pipelined received-power lane for one station: distance, log2 by squaring, dB scaling.
module chps_power #(
    parameter int COORD_BITS = 11
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [9:0]            pos_x,
    input  logic [9:0]            pos_y,
    input  logic [COORD_BITS-1:0] stn_x,
    input  logic [COORD_BITS-1:0] stn_y,
    input  logic [6:0]            tx_power_db,
    output logic signed [15:0]    power
);
    import chps_pkg::*;

    localparam int CW  = (COORD_BITS > 10) ? COORD_BITS : 10;
    localparam int D2W = 2 * CW + 1;
    localparam int NW  = $clog2(D2W);
    localparam int LGW = NW + FRAC_BITS;
    localparam int PRW = LGW + 30;
    localparam int RW  = PRW - 44;

    logic signed [CW:0]  dx, dy;
    logic [CW-1:0]       ax, ay;
    logic [2*CW-1:0]     sqx, sqy;
    logic [D2W-1:0]      d2_next, d2_reg;

    logic [D2W-1:0]      d2b_reg;
    logic [NW-1:0]       n_next, nb_reg;
    logic                zb_reg;

    logic [D2W+29:0]     shifted;

    logic [MANT_BITS-1:0] m_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] fr_reg [0:FRAC_BITS];
    logic [NW-1:0]        n_reg [0:FRAC_BITS];
    logic                 z_reg [0:FRAC_BITS];

    logic [LGW-1:0]      lg;
    logic [PRW-1:0]      prod;
    logic [PRW-1:0]      rounded;
    logic [RW-1:0]       r_reg;
    logic                zr_reg;

    logic signed [17:0]  base;
    logic signed [17:0]  v;
    logic signed [15:0]  power_next, power_reg;

    always_comb begin
        dx = $signed({{(CW + 1 - 10){1'b0}}, pos_x})
           - $signed({{(CW + 1 - COORD_BITS){1'b0}}, stn_x});
        dy = $signed({{(CW + 1 - 10){1'b0}}, pos_y})
           - $signed({{(CW + 1 - COORD_BITS){1'b0}}, stn_y});
        ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        sqx = ax * ax;
        sqy = ay * ay;
        d2_next = {1'b0, sqx} + {1'b0, sqy};
    end

    always_comb begin
        n_next = '0;
        for (int i = 0; i < D2W; i++) begin
            if (d2_reg[i]) begin
                n_next = NW'(i);
            end
        end
    end

    assign shifted = {d2b_reg, 30'b0} >> nb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg    <= d2_next;
            d2b_reg   <= d2_reg;
            nb_reg    <= n_next;
            zb_reg    <= (d2_reg == '0);
            m_reg[0]  <= shifted[MANT_BITS-1:0];
            fr_reg[0] <= '0;
            n_reg[0]  <= nb_reg;
            z_reg[0]  <= zb_reg;
        end
    end

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
        logic [2*MANT_BITS-1:0] sq;
        logic [31:0]            t;
        assign sq = m_reg[k] * m_reg[k];
        assign t  = sq[61:30];
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[k+1]  <= t[31] ? t[31:1] : t[30:0];
                fr_reg[k+1] <= {fr_reg[k][FRAC_BITS-2:0], t[31]};
                n_reg[k+1]  <= n_reg[k];
                z_reg[k+1]  <= z_reg[k];
            end
        end
    end

    always_comb begin
        lg      = {n_reg[FRAC_BITS], fr_reg[FRAC_BITS]};
        prod    = PRW'(lg) * PRW'(TEN_LOG10_2_Q28);
        rounded = (prod + (PRW'(1) << 43)) >> 44;
        base    = $signed({3'b0, tx_power_db, 8'b0}) - 18'sd8448;
        v       = base - $signed({{(18 - RW){1'b0}}, r_reg});
        if (zr_reg) begin
            power_next = PWR_MAX;
        end else if (v > 18'sd32767) begin
            power_next = PWR_MAX;
        end else if (v < -18'sd32768) begin
            power_next = PWR_MIN;
        end else begin
            power_next = v[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg     <= rounded[RW-1:0];
            zr_reg    <= z_reg[FRAC_BITS];
            power_reg <= power_next;
        end
    end

    assign power = power_reg;

endmodule

[rtl/chps_checker.sv]
// Port-level checker for the cell handoff policy select unit, with its bind.
module chps_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [chps_pkg::OUT_W-1:0] m_tdata
);
    import chps_pkg::*;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The input side is ready exactly when the output stage can move.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // No result appears right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The padding bits of a result are zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:OUT_W-2] == 2'b00)
        else $error("result padding not zero");

endmodule

bind cell_handoff_policy_select_unit chps_checker u_chps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/cell_handoff_policy_select_unit_tb.sv]
// Self-checking testbench for the cell handoff policy select unit.
module cell_handoff_policy_select_unit_tb;
    import chps_pkg::*;

    typedef struct {
        logic [1:0]         srv;
        logic signed [15:0] srv_pwr;
        logic [1:0]         alt;
        logic signed [15:0] alt_pwr;
        logic               srv_ho;
        logic               alt_ho;
    } handoff_result_t;

    class handoff_scoreboard;
        policy_mode_t    mode;
        longint          thr_db;
        longint          hys_db;
        longint          min_db;
        longint          tx_db;
        logic [43:0]     sta_x;
        logic [43:0]     sta_y;
        handoff_result_t handoff_q[$];
        int              mismatches;

        function new();
            mode       = MODE_BEST;
            thr_db     = 15;
            hys_db     = 13;
            min_db     = 10;
            tx_db      = 100;
            sta_x      = 44'd5498943611240;
            sta_y      = 44'd2664349078184;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [43:0] val);
            case (addr)
                REG_POLICY_MODE: mode   = policy_mode_t'(val[1:0]);
                REG_THRESHOLD:   thr_db = longint'($signed(val[7:0]));
                REG_HYSTERESIS:  hys_db = longint'(val[6:0]);
                REG_MIN_LEVEL:   min_db = longint'($signed(val[7:0]));
                REG_TX_POWER:    tx_db  = longint'(val[6:0]);
                REG_STATION_X:   sta_x  = val;
                REG_STATION_Y:   sta_y  = val;
                default: ;
            endcase
        endfunction

        function longint rx_power(int px, int py, int st);
            longint            dx, dy, v;
            longint unsigned   d2, t, m, frac, lg, r;
            int                n;
            dx = longint'(px - int'(sta_x[st*11 +: 11]));
            dy = longint'(py - int'(sta_y[st*11 +: 11]));
            d2 = dx * dx + dy * dy;
            if (d2 == 0) return 32767;
            n = 0;
            for (t = d2; t > 1; t = t >> 1) n++;
            m = (n <= 30) ? (d2 << (30 - n)) : (d2 >> (n - 30));
            frac = 0;
            for (int k = 0; k < 24; k++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    frac = frac | 64'd1;
                end
            end
            lg = (longint'(n) << 24) | frac;
            r = (lg * 64'd808071242 + (64'd1 << 43)) >> 44;
            v = (tx_db - 33) * 256 - longint'(r);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v;
        endfunction

        function bit beats(longint pnew, longint pcur);
            longint thr, hys;
            thr = thr_db * 256;
            hys = hys_db * 256;
            case (mode)
                MODE_BEST:   return pnew > pcur;
                MODE_THRESH: return pnew > pcur && pcur < thr;
                MODE_HYST:   return pnew > pcur + hys;
                default:     return pcur < thr && pnew > pcur + hys;
            endcase
        endfunction

        function void note_request(logic [23:0] d);
            int              px, py;
            longint          psrv, palt, p;
            handoff_result_t e;
            px = int'(d[9:0]);
            py = int'(d[19:10]);
            e.srv = d[21:20];
            e.alt = d[23:22];
            psrv = rx_power(px, py, int'(e.srv));
            palt = rx_power(px, py, int'(e.alt));
            for (int i = 0; i < 4; i++) begin
                p = rx_power(px, py, i);
                if (beats(p, psrv)) begin
                    psrv  = p;
                    e.srv = i[1:0];
                end
                if (beats(p, palt) && palt < min_db * 256) begin
                    palt  = p;
                    e.alt = i[1:0];
                end
            end
            e.srv_pwr = psrv[15:0];
            e.alt_pwr = palt[15:0];
            e.srv_ho  = e.srv != d[21:20];
            e.alt_ho  = e.alt != d[23:22];
            handoff_q = {handoff_q, e};
        endfunction

        function void check_result(logic [39:0] d);
            handoff_result_t e;
            bit              bad;
            if (handoff_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", d);
                return;
            end
            e = handoff_q.pop_front();
            bad = d[1:0] !== e.srv || d[17:2] !== e.srv_pwr || d[19:18] !== e.alt
                  || d[35:20] !== e.alt_pwr || d[36] !== e.srv_ho || d[37] !== e.alt_ho;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected srv %0d pwr %0d alt %0d pwr %0d ho %b%b,",
                             e.srv, e.srv_pwr, e.alt, e.alt_pwr, e.srv_ho, e.alt_ho,
                             " got srv %0d pwr %0d alt %0d pwr %0d ho %b%b",
                             d[1:0], $signed(d[17:2]), d[19:18], $signed(d[35:20]),
                             d[36], d[37]);
            end
        endfunction

        function int pending();
            return handoff_q.size();
        endfunction
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we = 0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [43:0]           cfg_wdata = '0;

    handoff_scoreboard sb = new();
    int send_idle_pct = 21;
    int recv_idle_pct = 50;
    int hold_cycles = 0;
    int sent = 0;

    cell_handoff_policy_select_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [43:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(addr, val);
        @(posedge aclk);
    endtask

    task automatic send_request(logic [9:0] px, logic [9:0] py, logic [1:0] srv,
                                logic [1:0] alt, bit may_idle);
        while (may_idle && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {alt, srv, py, px};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (sent == 320) begin
            send_idle_pct = 50;
            recv_idle_pct = 21;
        end else if (sent == 640) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_requests(int count, bit may_idle);
        int          st, c;
        logic [9:0]  px, py;
        for (int i = 0; i < count; i++) begin
            st = $urandom_range(3);
            case ($urandom_range(9))
                0: begin
                    px = (sb.sta_x[st*11 +: 11] > 1023) ? 10'd1023 : sb.sta_x[st*11 +: 10];
                    py = (sb.sta_y[st*11 +: 11] > 1023) ? 10'd1023 : sb.sta_y[st*11 +: 10];
                end
                1, 2, 3, 4, 5: begin
                    c  = int'(sb.sta_x[st*11 +: 11]) + $urandom_range(60) - 30;
                    px = (c < 0) ? 10'd0 : (c > 1023) ? 10'd1023 : c[9:0];
                    c  = int'(sb.sta_y[st*11 +: 11]) + $urandom_range(60) - 30;
                    py = (c < 0) ? 10'd0 : (c > 1023) ? 10'd1023 : c[9:0];
                end
                default: begin
                    px = 10'($urandom);
                    py = 10'($urandom);
                end
            endcase
            send_request(px, py, 2'($urandom), 2'($urandom), may_idle);
        end
    endtask

    initial begin
        logic [9:0] dir_x [8];
        logic [9:0] dir_y [8];
        dir_x = '{10'd360, 10'd660, 10'd330, 10'd640, 10'd0, 10'd1023, 10'd0, 10'd1023};
        dir_y = '{10'd680, 10'd658, 10'd350, 10'd310, 10'd0, 10'd1023, 10'd1023, 10'd0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 20; i++)
            send_request(dir_x[i % 8], dir_y[i % 8], i[1:0], i[3:2], 1'b1);
        random_requests(50, 1'b1);
        drain();

        hold_cycles = 300;
        random_requests(80, 1'b0);
        drain();

        write_reg(REG_POLICY_MODE, 44'(MODE_THRESH));
        write_reg(REG_THRESHOLD, 44'd127);
        random_requests(70, 1'b1);
        drain();

        write_reg(REG_POLICY_MODE, 44'(MODE_HYST));
        write_reg(REG_HYSTERESIS, 44'd0);
        random_requests(70, 1'b1);
        drain();

        write_reg(REG_POLICY_MODE, 44'(MODE_BOTH));
        write_reg(REG_THRESHOLD, 44'h80);
        write_reg(REG_HYSTERESIS, 44'd127);
        random_requests(60, 1'b1);
        drain();

        write_reg(REG_THRESHOLD, 44'd40);
        write_reg(REG_HYSTERESIS, 44'd5);
        write_reg(REG_MIN_LEVEL, 44'h80);
        random_requests(70, 1'b1);
        drain();

        write_reg(REG_POLICY_MODE, 44'(MODE_HYST));
        write_reg(REG_MIN_LEVEL, 44'd127);
        write_reg(REG_HYSTERESIS, 44'd3);
        random_requests(70, 1'b1);
        drain();

        write_reg(REG_POLICY_MODE, 44'(MODE_THRESH));
        write_reg(REG_TX_POWER, 44'd0);
        write_reg(REG_THRESHOLD, 44'hE2);
        random_requests(70, 1'b1);
        drain();

        write_reg(REG_POLICY_MODE, 44'(MODE_BOTH));
        write_reg(REG_TX_POWER, 44'd127);
        write_reg(REG_THRESHOLD, 44'd60);
        random_requests(70, 1'b1);
        drain();

        write_reg(REG_POLICY_MODE, 44'(MODE_BEST));
        write_reg(REG_STATION_X, 44'({$urandom, $urandom}));
        write_reg(REG_STATION_Y, 44'({$urandom, $urandom}));
        random_requests(70, 1'b1);
        drain();

        write_reg(REG_STATION_X, {44{1'b1}});
        write_reg(REG_STATION_Y, {44{1'b1}});
        random_requests(60, 1'b1);
        drain();

        write_reg(REG_STATION_X, 44'd0);
        write_reg(REG_STATION_Y, 44'd0);
        write_reg(REG_MIN_LEVEL, 44'd50);
        random_requests(60, 1'b1);
        drain();

        for (int ph = 0; ph < 2; ph++) begin
            write_reg(REG_POLICY_MODE, 44'($urandom_range(3)));
            write_reg(REG_THRESHOLD, 44'($urandom_range(255)));
            write_reg(REG_HYSTERESIS, 44'($urandom_range(20)));
            write_reg(REG_MIN_LEVEL, 44'($urandom_range(255)));
            write_reg(REG_TX_POWER, 44'($urandom_range(127)));
            write_reg(REG_STATION_X, 44'({$urandom, $urandom}) & {4{11'h3FF}});
            write_reg(REG_STATION_Y, 44'({$urandom, $urandom}) & {4{11'h3FF}});
            random_requests(75, 1'b1);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/chps_pkg.sv
rtl/chps_power.sv
rtl/cell_handoff_policy_select_unit.sv
rtl/chps_checker.sv
sim/cell_handoff_policy_select_unit_tb.sv
